// ===== src/pcmr_pkg.sv =====
// Package for the PCM sample player with nearest-sample resampling.
// Holds the command and register codes, the memory and queue sizes and the shared types.
// No dependencies.
package pcmr_pkg;

  localparam int MEM_HALFWORDS = 16384;
  localparam int MEM_AW = $clog2(MEM_HALFWORDS);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] REG_STEREO_MODE = 2'd0;
  localparam logic [1:0] REG_RATE_RATIO = 2'd1;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd2;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd3;

  localparam logic [17:0] RATE_RATIO_RESET = 18'd65536;
  localparam logic [14:0] FRAME_COUNT_RESET = 15'd16384;

  typedef struct packed {
    logic        stereo_mode;
    logic [17:0] rate_ratio;
    logic [14:0] frame_count;
    logic        loop_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] load_addr;
    logic [15:0] load_data;
  } item_t;

endpackage

// ===== src/pcmr_front.sv =====
// Front end of the sample player: accepts input transfers, drops unused command codes
// and queues the rest in a short FIFO for the back end. Depends on pcmr_pkg.
module pcmr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [13:0]        in_load_addr,
  input  logic signed [15:0] in_load_data,
  output logic               q_valid,
  output pcmr_pkg::item_t    q_item,
  input  logic               q_pop
);
  import pcmr_pkg::*;

  item_t            queue_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r;
  logic [Q_CW-1:0]  cnt_nxt;
  logic             push;
  logic             pop;

  assign in_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = queue_r[rd_ptr_r];

  assign push = in_valid && in_ready && (in_cmd inside {CMD_LOAD, CMD_TICK, CMD_RESTART});
  assign pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{cmd: in_cmd, load_addr: in_load_addr,
                             load_data: in_load_data};
    end
  end

endmodule

// ===== src/pcmr_back.sv =====
// Back end of the sample player: sample memory, phase accumulator, frame pointer,
// end and wrap handling and the output register. Depends on pcmr_pkg.
module pcmr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pcmr_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  pcmr_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_play_ended,
  output logic               out_wrapped
);
  import pcmr_pkg::*;

  logic [15:0]       sample_mem_r [MEM_HALFWORDS];
  logic [15:0]       rd0_r;
  logic [15:0]       rd1_r;
  logic [15:0]       fp_r;
  logic [15:0]       fp_nxt;
  logic [15:0]       frac_r;
  logic [15:0]       frac_nxt;
  logic              ended_r;
  logic              ended_nxt;
  logic              wrap_nxt;
  logic              out_valid_r;
  logic              out_ended_r;
  logic              out_wrap_r;
  logic              slot_free;
  logic              is_load;
  logic              is_tick;
  logic              is_restart;
  logic [18:0]       acc;
  logic [16:0]       ptr;
  logic              hit;
  logic [MEM_AW-1:0] rd_addr0;
  logic [MEM_AW-1:0] rd_addr1;
  logic [MEM_AW-1:0] wr_addr;

  assign slot_free  = !out_valid_r || out_ready;
  assign q_pop      = q_valid && ((q_item.cmd != CMD_TICK) || slot_free);
  assign is_load    = q_pop && (q_item.cmd == CMD_LOAD);
  assign is_tick    = q_pop && (q_item.cmd == CMD_TICK);
  assign is_restart = q_pop && (q_item.cmd == CMD_RESTART);

  assign acc = 19'(frac_r) + 19'(cfg.rate_ratio);
  assign ptr = 17'(fp_r) + 17'(acc[18:16]);
  assign hit = (ptr >= 17'(cfg.frame_count));

  always_comb begin
    fp_nxt    = fp_r;
    frac_nxt  = frac_r;
    ended_nxt = ended_r;
    wrap_nxt  = 1'b0;
    if (is_restart) begin
      fp_nxt    = '0;
      frac_nxt  = '0;
      ended_nxt = 1'b0;
    end else if (is_tick && !ended_r) begin
      if (hit && !cfg.loop_enable) begin
        ended_nxt = 1'b1;
      end else begin
        fp_nxt   = hit ? '0 : ptr[15:0];
        frac_nxt = acc[15:0];
        wrap_nxt = hit;
      end
    end
  end

  assign rd_addr0 = cfg.stereo_mode ? MEM_AW'({fp_nxt, 1'b0}) : MEM_AW'(fp_nxt);
  assign rd_addr1 = cfg.stereo_mode ? MEM_AW'({fp_nxt, 1'b1}) : MEM_AW'(fp_nxt);
  assign wr_addr  = MEM_AW'(q_item.load_addr);

  always_ff @(posedge clk) begin
    if (is_load) begin
      sample_mem_r[wr_addr] <= q_item.load_data;
    end
    if (is_tick) begin
      rd0_r <= sample_mem_r[rd_addr0];
      rd1_r <= sample_mem_r[rd_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r        <= '0;
      frac_r      <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_ended_r <= 1'b0;
      out_wrap_r  <= 1'b0;
    end else begin
      fp_r    <= fp_nxt;
      frac_r  <= frac_nxt;
      ended_r <= ended_nxt;
      if (is_tick) begin
        out_valid_r <= 1'b1;
        out_ended_r <= ended_nxt;
        out_wrap_r  <= wrap_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_ended_r ? '0 : rd0_r;
  assign out_right_sample = out_ended_r ? '0 : rd1_r;
  assign out_play_ended   = out_ended_r;
  assign out_wrapped      = out_wrap_r;

  a_tick_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |-> slot_free)
    else $error("tick taken from the queue while the output register is occupied");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ended_r && out_wrap_r))
    else $error("result marks both end of playback and a wrap");

  a_ended_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r && !is_restart |=> ended_r && $stable(fp_r) && $stable(frac_r))
    else $error("playback state changed while ended");

  a_wrap_clears_pointer: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick && wrap_nxt |=> (fp_r == '0) && out_wrap_r)
    else $error("wrap did not clear the frame pointer");

endmodule

// ===== src/pcm_sample_player_resampler.sv =====
// PCM sample player with nearest-sample resampling: configuration registers,
// front queue and playback back end. Depends on pcmr_pkg, pcmr_front and pcmr_back.
// Throughput: one item per cycle, but a tick waits in the front queue while the output
// register holds an untaken result; a tick passes the queue, then the output register.
// Reset: pointer, fraction and ended flag clear, registers take their reset values;
// the sample memory is not cleared and holds undefined data until loaded.
module pcm_sample_player_resampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [13:0]        in_load_addr,
  input  logic signed [15:0] in_load_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample,
  output logic               out_play_ended,
  output logic               out_wrapped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import pcmr_pkg::*;

  cfg_t  cfg_r;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo_mode <= 1'b1;
      cfg_r.rate_ratio  <= RATE_RATIO_RESET;
      cfg_r.frame_count <= FRAME_COUNT_RESET;
      cfg_r.loop_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEREO_MODE: cfg_r.stereo_mode <= cfg_data[0];
        REG_RATE_RATIO:  cfg_r.rate_ratio  <= cfg_data;
        REG_FRAME_COUNT: cfg_r.frame_count <= cfg_data[14:0];
        REG_LOOP_ENABLE: cfg_r.loop_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pcmr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_load_addr (in_load_addr),
    .in_load_data (in_load_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  pcmr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_play_ended   (out_play_ended),
    .out_wrapped      (out_wrapped)
  );

endmodule

// ===== sim/pcm_sample_player_resampler_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pcm_sample_player_resampler: sends load, tick and restart
// transfers, predicts every output frame from a shadow copy of the player and compares.
// Depends on pcmr_pkg and the RTL in src.
module pcm_sample_player_resampler_test;
  import pcmr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               ended;
    logic               wrapped;
  } frame_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = CMD_LOAD;
  logic [13:0]        in_load_addr = '0;
  logic signed [15:0] in_load_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic               out_play_ended;
  logic               out_wrapped;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_STEREO_MODE;
  logic [17:0]        cfg_data = '0;

  pcm_sample_player_resampler DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_load_addr     (in_load_addr),
    .in_load_data     (in_load_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .out_play_ended   (out_play_ended),
    .out_wrapped      (out_wrapped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the player.
  logic [15:0] pcm_mem [MEM_HALFWORDS];
  bit          pcm_loaded [MEM_HALFWORDS];
  logic [15:0] play_ptr = '0;
  logic [15:0] play_frac = '0;
  bit          play_ended = 1'b0;
  logic        stereo_q = 1'b1;
  logic [17:0] rate_q = RATE_RATIO_RESET;
  logic [14:0] count_q = FRAME_COUNT_RESET;
  logic        loop_q = 1'b1;

  frame_t expected_frames[$];
  frame_t got_frame, want_frame;

  bit calm = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int frames_checked = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int restarts_sent = 0;
  int wraps_seen = 0;
  int ends_seen = 0;

  // Returns 1 if a tick now keeps playback running; p and f are the new pointer and fraction.
  function automatic bit tick_target(output logic [15:0] p, output logic [15:0] f,
                                     output bit wraps);
    logic [31:0] acc, nxt;
    p = play_ptr;
    f = play_frac;
    wraps = 1'b0;
    if (play_ended) return 1'b0;
    acc = 32'(play_frac) + 32'(rate_q);
    nxt = 32'(play_ptr) + (acc >> 16);
    if (nxt >= 32'(count_q)) begin
      if (!loop_q) return 1'b0;
      nxt = '0;
      wraps = 1'b1;
    end
    p = nxt[15:0];
    f = acc[15:0];
    return 1'b1;
  endfunction

  function automatic logic [13:0] frame_addr(logic [15:0] p, bit side);
    return stereo_q ? {p[12:0], side} : p[13:0];
  endfunction

  function automatic void apply_item(logic [1:0] cmd, logic [13:0] addr, logic [15:0] data);
    frame_t      r;
    logic [15:0] p, f;
    bit          w;
    case (cmd)
      CMD_LOAD: begin
        pcm_mem[addr] = data;
        pcm_loaded[addr] = 1'b1;
        loads_sent++;
      end
      CMD_TICK: begin
        r = '0;
        if (tick_target(p, f, w)) begin
          play_ptr = p;
          play_frac = f;
          r.left = pcm_mem[frame_addr(p, 1'b0)];
          r.right = stereo_q ? pcm_mem[frame_addr(p, 1'b1)] : r.left;
          r.wrapped = w;
        end else begin
          play_ended = 1'b1;
          r.ended = 1'b1;
        end
        expected_frames.push_back(r);
      end
      CMD_RESTART: begin
        play_ptr = '0;
        play_frac = '0;
        play_ended = 1'b0;
        restarts_sent++;
      end
      default: ;
    endcase
  endfunction

  // Valid is left high on return so that a following item can go out without a gap.
  task automatic send_item(logic [1:0] cmd, logic [13:0] addr, logic [15:0] data);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_load_addr <= addr;
    in_load_data <= data;
    do @(posedge clk); while (!in_ready);
    apply_item(cmd, addr, data);
    items_sent++;
  endtask

  // Loads any halfword that the tick would read before it was ever written, then ticks.
  task automatic send_tick();
    logic [15:0] p, f;
    bit          w;
    if (tick_target(p, f, w)) begin
      if (!pcm_loaded[frame_addr(p, 1'b0)])
        send_item(CMD_LOAD, frame_addr(p, 1'b0), 16'($urandom));
      if (stereo_q && !pcm_loaded[frame_addr(p, 1'b1)])
        send_item(CMD_LOAD, frame_addr(p, 1'b1), 16'($urandom));
    end
    send_item(CMD_TICK, 14'($urandom), 16'($urandom));
  endtask

  task automatic send_restart();
    send_item(CMD_RESTART, 14'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STEREO_MODE: stereo_q = value[0];
      REG_RATE_RATIO:  rate_q = value;
      REG_FRAME_COUNT: count_q = value[14:0];
      REG_LOOP_ENABLE: loop_q = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_player(logic stereo, logic [17:0] rate, logic [14:0] count,
                                logic loop_on);
    drain();
    write_reg(REG_STEREO_MODE, 18'(stereo));
    write_reg(REG_RATE_RATIO, rate);
    write_reg(REG_FRAME_COUNT, 18'(count));
    write_reg(REG_LOOP_ENABLE, 18'(loop_on));
  endtask

  task automatic test_reset_values();
    send_item(CMD_LOAD, 14'h3fff, 16'h7fff);
    send_item(CMD_LOAD, 14'h0000, 16'h8000);
    send_item(CMD_LOAD, 14'h0001, 16'hffff);
    repeat (4) send_tick();
  endtask

  task automatic test_mono_loop();
    program_player(1'b0, 18'd148607, 15'd5, 1'b1);
    send_restart();
    repeat (6) send_tick();
  endtask

  task automatic test_end_of_play();
    program_player(1'b1, 18'd65536, 15'd3, 1'b0);
    send_restart();
    repeat (5) send_tick();
    drain();
    // Setting loop mode while ended must not bring playback back.
    write_reg(REG_LOOP_ENABLE, 18'd1);
    send_tick();
    send_restart();
    send_tick();
  endtask

  task automatic test_zero_frame_count();
    drain();
    write_reg(REG_FRAME_COUNT, 18'd0);
    repeat (3) send_tick();
    drain();
    write_reg(REG_LOOP_ENABLE, 18'd0);
    repeat (2) send_tick();
    send_restart();
  endtask

  task automatic test_zero_rate();
    program_player(1'b0, 18'd0, 15'd16384, 1'b1);
    send_restart();
    repeat (3) send_tick();
  endtask

  task automatic test_unused_command();
    send_item(CMD_UNUSED, 14'h3fff, 16'hffff);
    send_tick();
    send_item(CMD_UNUSED, 14'h0000, 16'h0000);
    send_tick();
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 64;
    repeat (12) send_tick();
    drain();
    repeat (6) send_tick();
  endtask

  task automatic test_random_phases(int phases, int items_per_phase);
    int          sel;
    logic [17:0] rate;
    logic [14:0] count;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 7))
        0: rate = 18'd0;
        1: rate = 18'd1;
        2: rate = 18'd148607;
        3: rate = 18'h3ffff;
        default: rate = 18'($urandom_range(1, 148607));
      endcase
      case ($urandom_range(0, 7))
        0: count = 15'd0;
        1: count = 15'd1;
        2: count = 15'd16384;
        3: count = 15'h7fff;
        4: count = 15'($urandom_range(1, 16384));
        default: count = 15'($urandom_range(2, 40));
      endcase
      program_player(1'($urandom), rate, count, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) send_restart();
      for (int k = 0; k < items_per_phase; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) send_tick();
        else if (sel < 88) send_item(CMD_LOAD, 14'($urandom), 16'($urandom));
        else if (sel < 96) send_restart();
        else send_item(CMD_UNUSED, 14'($urandom), 16'($urandom));
      end
    end
  endtask

  // Streams looping stereo ticks at the highest rate with no idling on either side.
  task automatic test_full_rate_stream();
    program_player(1'b1, 18'h3ffff, 15'd64, 1'b1);
    calm = 1'b1;
    send_restart();
    repeat (150) send_tick();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_frame = {out_left_sample, out_right_sample, out_play_ended, out_wrapped};
      frames_checked++;
      if (got_frame.wrapped) wraps_seen++;
      if (got_frame.ended) ends_seen++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected frame: left %0d right %0d ended %0b wrapped %0b",
                   got_frame.left, got_frame.right, got_frame.ended, got_frame.wrapped);
      end else begin
        want_frame = expected_frames.pop_front();
        if (got_frame !== want_frame) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("frame %0d: expected left %0d right %0d ended %0b wrapped %0b,",
                     frames_checked, want_frame.left, want_frame.right, want_frame.ended,
                     want_frame.wrapped);
            $display("  got left %0d right %0d ended %0b wrapped %0b",
                     got_frame.left, got_frame.right, got_frame.ended, got_frame.wrapped);
          end
        end
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles", IDLE_LIMIT);
      $display("pcm_sample_player_resampler: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_mono_loop();
    test_end_of_play();
    test_zero_frame_count();
    test_zero_rate();
    test_unused_command();
    test_backpressure();
    test_random_phases(8, 60);
    test_full_rate_stream();
    drain();
    repeat (8) @(posedge clk);
    $display("%0d transfers in: %0d loads, %0d restarts; %0d frames checked",
             items_sent, loads_sent, restarts_sent, frames_checked);
    $display("%0d frames wrapped the pointer, %0d frames came after the end of play",
             wraps_seen, ends_seen);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("pcm_sample_player_resampler: match");
    end else begin
      $display("%0d bad frames, %0d frames never came", mismatches, expected_frames.size());
      $display("pcm_sample_player_resampler: mismatch");
    end
    $finish;
  end

endmodule
